>>> rtl/core/scs1asc_pkg.sv
// Package: scancode constants, key kinds, flag types and the set-1 ASCII lookup tables.
package scs1asc_pkg;

   // Scancode bytes with a special meaning
   localparam logic [7:0] SC_PREFIX      = 8'hE0;
   localparam logic [7:0] SC_ARROW_UP    = 8'h48;
   localparam logic [7:0] SC_ARROW_DOWN  = 8'h50;
   localparam logic [7:0] SC_ARROW_LEFT  = 8'h4B;
   localparam logic [7:0] SC_ARROW_RIGHT = 8'h4D;
   localparam logic [7:0] SC_LSHIFT_MAKE = 8'h2A;
   localparam logic [7:0] SC_RSHIFT_MAKE = 8'h36;
   localparam logic [7:0] SC_LSHIFT_BRK  = 8'hAA;
   localparam logic [7:0] SC_RSHIFT_BRK  = 8'hB6;
   localparam logic [7:0] SC_CTRL_MAKE   = 8'h1D;
   localparam logic [7:0] SC_CTRL_BRK    = 8'h9D;
   localparam logic [7:0] SC_CAPS_MAKE   = 8'h3A;

   // Key kinds on the result channel
   localparam logic [2:0] KIND_CHAR  = 3'd0;
   localparam logic [2:0] KIND_UP    = 3'd1;
   localparam logic [2:0] KIND_DOWN  = 3'd2;
   localparam logic [2:0] KIND_LEFT  = 3'd3;
   localparam logic [2:0] KIND_RIGHT = 3'd4;
   localparam logic [2:0] KIND_TAB   = 3'd5;

   // ASCII codes the decoder looks at
   localparam logic [6:0] ASCII_TAB       = 7'h09;
   localparam logic [6:0] ASCII_FORM_FEED = 7'h0C;
   localparam logic [6:0] ASCII_LOWER_A   = 7'h61;
   localparam logic [6:0] ASCII_LOWER_L   = 7'h6C;
   localparam logic [6:0] ASCII_LOWER_Z   = 7'h7A;

   // Keyboard state flags
   typedef struct packed {
      logic prefix;
      logic shift;
      logic ctrl;
      logic caps;
   } kbd_flags_type;

   // One decoded item
   typedef struct packed {
      logic       valid;
      logic [2:0] kind;
      logic [6:0] code;
   } key_result_type;

   // Unshifted table, make codes 0x00..0x3F; zero means unmapped
   function automatic logic [6:0] plain_lookup(input logic [5:0] idx);
      logic [6:0] r;
      case (idx)
         6'd2:    r = 7'h31;
         6'd3:    r = 7'h32;
         6'd4:    r = 7'h33;
         6'd5:    r = 7'h34;
         6'd6:    r = 7'h35;
         6'd7:    r = 7'h36;
         6'd8:    r = 7'h37;
         6'd9:    r = 7'h38;
         6'd10:   r = 7'h39;
         6'd11:   r = 7'h30;
         6'd12:   r = 7'h2D;
         6'd13:   r = 7'h3D;
         6'd14:   r = 7'h08;
         6'd15:   r = 7'h09;
         6'd16:   r = 7'h71;
         6'd17:   r = 7'h77;
         6'd18:   r = 7'h65;
         6'd19:   r = 7'h72;
         6'd20:   r = 7'h74;
         6'd21:   r = 7'h79;
         6'd22:   r = 7'h75;
         6'd23:   r = 7'h69;
         6'd24:   r = 7'h6F;
         6'd25:   r = 7'h70;
         6'd26:   r = 7'h5B;
         6'd27:   r = 7'h5D;
         6'd28:   r = 7'h0A;
         6'd30:   r = 7'h61;
         6'd31:   r = 7'h73;
         6'd32:   r = 7'h64;
         6'd33:   r = 7'h66;
         6'd34:   r = 7'h67;
         6'd35:   r = 7'h68;
         6'd36:   r = 7'h6A;
         6'd37:   r = 7'h6B;
         6'd38:   r = 7'h6C;
         6'd39:   r = 7'h3B;
         6'd40:   r = 7'h27;
         6'd41:   r = 7'h60;
         6'd43:   r = 7'h5C;
         6'd44:   r = 7'h7A;
         6'd45:   r = 7'h78;
         6'd46:   r = 7'h63;
         6'd47:   r = 7'h76;
         6'd48:   r = 7'h62;
         6'd49:   r = 7'h6E;
         6'd50:   r = 7'h6D;
         6'd51:   r = 7'h2C;
         6'd52:   r = 7'h2E;
         6'd53:   r = 7'h2F;
         6'd57:   r = 7'h20;
         default: r = 7'h00;
      endcase
      return r;
   endfunction

   // Shifted table, same index range
   function automatic logic [6:0] upper_lookup(input logic [5:0] idx);
      logic [6:0] r;
      case (idx)
         6'd2:    r = 7'h21;
         6'd3:    r = 7'h40;
         6'd4:    r = 7'h23;
         6'd5:    r = 7'h24;
         6'd6:    r = 7'h25;
         6'd7:    r = 7'h5E;
         6'd8:    r = 7'h26;
         6'd9:    r = 7'h2A;
         6'd10:   r = 7'h28;
         6'd11:   r = 7'h29;
         6'd12:   r = 7'h5F;
         6'd13:   r = 7'h2B;
         6'd14:   r = 7'h08;
         6'd15:   r = 7'h09;
         6'd16:   r = 7'h51;
         6'd17:   r = 7'h57;
         6'd18:   r = 7'h45;
         6'd19:   r = 7'h52;
         6'd20:   r = 7'h54;
         6'd21:   r = 7'h59;
         6'd22:   r = 7'h55;
         6'd23:   r = 7'h49;
         6'd24:   r = 7'h4F;
         6'd25:   r = 7'h50;
         6'd26:   r = 7'h7B;
         6'd27:   r = 7'h7D;
         6'd28:   r = 7'h0A;
         6'd30:   r = 7'h41;
         6'd31:   r = 7'h53;
         6'd32:   r = 7'h44;
         6'd33:   r = 7'h46;
         6'd34:   r = 7'h47;
         6'd35:   r = 7'h48;
         6'd36:   r = 7'h4A;
         6'd37:   r = 7'h4B;
         6'd38:   r = 7'h4C;
         6'd39:   r = 7'h3A;
         6'd40:   r = 7'h22;
         6'd41:   r = 7'h7E;
         6'd43:   r = 7'h7C;
         6'd44:   r = 7'h5A;
         6'd45:   r = 7'h58;
         6'd46:   r = 7'h43;
         6'd47:   r = 7'h56;
         6'd48:   r = 7'h42;
         6'd49:   r = 7'h4E;
         6'd50:   r = 7'h4D;
         6'd51:   r = 7'h3C;
         6'd52:   r = 7'h3E;
         6'd53:   r = 7'h3F;
         6'd57:   r = 7'h20;
         default: r = 7'h00;
      endcase
      return r;
   endfunction

endpackage

>>> rtl/core/scancode_set1_to_ascii_decoder_top.sv
// Top level: set-1 scancode to ASCII decoder with input and result registers.
//
// Takes one set-1 scancode byte per item and returns zero or one key item:
// a character, an arrow key after the 0xE0 prefix, or tab. Shift, ctrl and
// caps lock are tracked internally; modifier, prefix, break and unmapped codes
// give no result. An accepted byte sits in the input register while the decode
// logic runs; its result is loaded into the result register, and so onto rsp_,
// once that register is free to take it. One item is taken every
// cycle as long as the result register drains; req_stall rises only when the
// input register holds a byte and the result register is full and stalled.
module scancode_set1_to_ascii_decoder_top
   import scs1asc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_scan_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_key_kind,
   output logic [6:0] rsp_char_code
);

   logic           in_valid_ff;
   logic           in_valid_in;
   logic [7:0]     in_byte_ff;
   kbd_flags_type  flags_ff;
   kbd_flags_type  flags_in;
   kbd_flags_type  flags_next;
   key_result_type dec_result;
   logic           out_valid_ff;
   logic           out_valid_in;
   logic [2:0]     out_kind_ff;
   logic [6:0]     out_code_ff;
   logic           out_free;
   logic           in_move;
   logic           req_take;

   // Handshake and stage advance
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign in_move   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   // Decode the byte held in the input register
   scs1asc_decode u_decode (
      .scan_byte  (in_byte_ff),
      .flags      (flags_ff),
      .flags_next (flags_next),
      .result     (dec_result)
   );

   // Next values of control state
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (in_move) begin
         in_valid_in = 1'b0;
      end
      flags_in = in_move ? flags_next : flags_ff;
      out_valid_in = out_valid_ff;
      if (in_move) begin
         out_valid_in = dec_result.valid;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         flags_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         flags_ff     <= flags_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_scan_byte;
      end
      if (in_move && dec_result.valid) begin
         out_kind_ff <= dec_result.kind;
         out_code_ff <= dec_result.code;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_key_kind  = out_kind_ff;
   assign rsp_char_code = out_code_ff;

   // Only characters carry a code
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_key_kind != KIND_CHAR) |-> (rsp_char_code == 7'h00))
      else $error("non-character item carries a nonzero code");

   // Any byte after the prefix clears it
   assert property (@(posedge clock) disable iff (reset)
      (in_move && flags_ff.prefix) |=> !flags_ff.prefix)
      else $error("prefix flag not cleared by following byte");

   // Caps lock make code toggles caps when no prefix is pending
   assert property (@(posedge clock) disable iff (reset)
      (in_move && !flags_ff.prefix && in_byte_ff == SC_CAPS_MAKE)
      |=> (flags_ff.caps != $past(flags_ff.caps)))
      else $error("caps lock did not toggle");

   // Flags change only when an item leaves the input register
   assert property (@(posedge clock) disable iff (reset)
      !in_move |=> $stable(flags_ff))
      else $error("flags changed without an item");

   // Stall is raised only with a byte waiting and a full result register
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff))
      else $error("input stalled with room downstream");

endmodule

>>> rtl/core/scs1asc_decode.sv
// Decode logic: one scancode byte plus current flags gives next flags and an optional key item.
module scs1asc_decode
   import scs1asc_pkg::*;
(
   input  logic [7:0]     scan_byte,
   input  kbd_flags_type  flags,
   output kbd_flags_type  flags_next,
   output key_result_type result
);

   logic [6:0] base_code;
   logic [6:0] shifted_code;
   logic       in_table;
   logic       is_letter;
   logic       use_upper;

   // Table lookups for make codes below 0x40
   assign in_table     = (scan_byte[7:6] == 2'b00);
   assign base_code    = plain_lookup(scan_byte[5:0]);
   assign shifted_code = upper_lookup(scan_byte[5:0]);
   assign is_letter    = (base_code >= ASCII_LOWER_A) && (base_code <= ASCII_LOWER_Z);
   assign use_upper    = is_letter ? (flags.shift ^ flags.caps) : flags.shift;

   // Prefix handling, modifier tracking and character selection
   always_comb begin
      flags_next   = flags;
      result.valid = 1'b0;
      result.kind  = KIND_CHAR;
      result.code  = '0;
      if (flags.prefix) begin
         flags_next.prefix = 1'b0;
         unique case (scan_byte)
            SC_ARROW_UP: begin
               result.valid = 1'b1;
               result.kind  = KIND_UP;
            end
            SC_ARROW_DOWN: begin
               result.valid = 1'b1;
               result.kind  = KIND_DOWN;
            end
            SC_ARROW_LEFT: begin
               result.valid = 1'b1;
               result.kind  = KIND_LEFT;
            end
            SC_ARROW_RIGHT: begin
               result.valid = 1'b1;
               result.kind  = KIND_RIGHT;
            end
            default: ;
         endcase
      end else begin
         unique case (scan_byte) inside
            SC_PREFIX:                      flags_next.prefix = 1'b1;
            SC_LSHIFT_MAKE, SC_RSHIFT_MAKE: flags_next.shift  = 1'b1;
            SC_LSHIFT_BRK, SC_RSHIFT_BRK:   flags_next.shift  = 1'b0;
            SC_CTRL_MAKE:                   flags_next.ctrl   = 1'b1;
            SC_CTRL_BRK:                    flags_next.ctrl   = 1'b0;
            SC_CAPS_MAKE:                   flags_next.caps   = ~flags.caps;
            default: begin
               if (in_table && (base_code != 7'h00)) begin
                  result.valid = 1'b1;
                  if (flags.ctrl && (base_code == ASCII_LOWER_L)) begin
                     result.code = ASCII_FORM_FEED;
                  end else if (base_code == ASCII_TAB) begin
                     result.kind = KIND_TAB;
                  end else begin
                     result.code = use_upper ? shifted_code : base_code;
                  end
               end
            end
         endcase
      end
   end

endmodule
